### design/bitmap_page_run_allocator_core_assert.svh
// Assertion macros shared by the allocator RTL
`ifndef BITMAP_PAGE_RUN_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_RUN_ALLOCATOR_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define BPRA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset
`define BPRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/bpra_pkg.sv
// ----------------------------------------------------------------------------
// bpra_pkg
// Shared types and constants of the bitmap page-run allocator.
// ----------------------------------------------------------------------------
package bpra_pkg;

  localparam int MaxPages    = 65536;
  localparam int MapWordBits = 64;
  localparam int PageShift   = 12;
  localparam int CountW      = 17;
  localparam int AddrW       = 64;
  localparam int StatusW     = 2;

  localparam logic [1:0] CfgEnable = 2'd0;
  localparam logic [1:0] CfgBase   = 2'd1;
  localparam logic [1:0] CfgPages  = 2'd2;

  localparam logic KindAlloc = 1'b0;
  localparam logic KindFree  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_UNAVAIL = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_REJECT  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_LD,
    S_SCAN,
    S_WR_RD,
    S_WR_LD,
    S_WR,
    S_DONE,
    S_OUT
  } state_t;

endpackage

### design/bpra_map.sv
// ----------------------------------------------------------------------------
// bpra_map
// Page map storage: word memory with registered read, zeroed one word per
// cycle after reset while busy is high.
// ----------------------------------------------------------------------------
module bpra_map #(
  parameter int MAX_PAGES     = bpra_pkg::MaxPages,
  parameter int MAP_WORD_BITS = bpra_pkg::MapWordBits,
  localparam int Words = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
  localparam int WaW   = (Words > 1) ? $clog2(Words) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  output logic                     busy,
  input  logic [WaW-1:0]           rd_addr,
  output logic [MAP_WORD_BITS-1:0] rd_data,
  input  logic                     wr_en,
  input  logic [WaW-1:0]           wr_addr,
  input  logic [MAP_WORD_BITS-1:0] wr_data
);

  logic [MAP_WORD_BITS-1:0] mem [Words];
  logic [MAP_WORD_BITS-1:0] mem_q;
  logic [WaW-1:0]           clr_addr;

  // zero one word per cycle after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == WaW'(Words - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  assign rd_data = mem_q;

endmodule

### design/bitmap_page_run_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_page_run_allocator_core
// First-fit page-run allocator over a bitmap of pool pages.
// ----------------------------------------------------------------------------
// Usage: requests enter on in_valid/in_stall with kind, page_count and
// address; each request gives one result on out_valid/out_stall with status
// and alloc_address. Configuration writes (cfg_we, cfg_index, cfg_data) must
// be made only while the block is idle; the block itself does not enforce it.
// One request is worked at a time; in_stall is high from acceptance until
// the sequencer returns to idle. The sequencer walks the map one page per
// cycle, pausing at each new map word, through a single run counter and
// compare unit; a map word is addressed in a RD state and its registered
// read data loaded in the LD state. Rejected, disabled, zero-count free and
// empty-pool requests go from the check state straight to the output state.
// Allocate: check, then per map word scanned a read and a load state and a
// scan step per page examined; if a run is found, per word marked a read and
// a load state and a write step per page marked, then done and output.
// Free: check, then the same marking over the freed run, done and output.
// Reset clears the state, out_valid and configuration, then zeroes the map
// one word per cycle (1024 words for 65536 pages) with in_stall held high.
// While the receiver stalls, the result holds in the output register; one
// more request may be taken and worked, and its result waits for the slot.
// ----------------------------------------------------------------------------
`include "bitmap_page_run_allocator_core_assert.svh"

module bitmap_page_run_allocator_core #(
  parameter int MAX_PAGES     = bpra_pkg::MaxPages,
  parameter int MAP_WORD_BITS = bpra_pkg::MapWordBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [16:0] page_count,
  input  logic [63:0] address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] alloc_address
);

  localparam int Words = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WaW   = (Words > 1) ? $clog2(Words) : 1;
  localparam int BiW   = $clog2(MAP_WORD_BITS);
  localparam int PW    = $clog2(MAX_PAGES) + 1;

  // configuration
  logic        pool_enable;
  logic [63:0] pool_base;
  logic [16:0] pool_pages;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_enable <= 1'b0;
      pool_base   <= '0;
      pool_pages  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpra_pkg::CfgEnable: pool_enable <= cfg_data[0];
        bpra_pkg::CfgBase:   pool_base   <= cfg_data;
        bpra_pkg::CfgPages:  pool_pages  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  bpra_pkg::state_t state, state_next;

  logic        req_kind;
  logic [16:0] req_count;
  logic [63:0] req_addr;
  logic [PW-1:0] total;
  logic [PW-1:0] p;        // current page
  logic [PW-1:0] start;    // run start page
  logic [PW-1:0] wr_end;   // one past last page to write
  logic [16:0]   run;
  logic [MAP_WORD_BITS-1:0] word;
  logic [1:0]    res_status;
  logic [63:0]   res_addr;

  // free-address math
  logic [63:0] off;
  logic [52:0] first;
  assign off   = req_addr - pool_base;
  assign first = {1'b0, off[63:bpra_pkg::PageShift]} + {52'd0, |off[11:0]};

  logic [53:0] free_end;
  assign free_end = {1'b0, first} + {37'd0, req_count};

  // map port
  logic [WaW-1:0]           rd_addr, wr_addr;
  logic [MAP_WORD_BITS-1:0] rd_data, wr_data;
  logic                     wr_en;
  logic                     map_busy;

  bpra_map #(.MAX_PAGES(MAX_PAGES), .MAP_WORD_BITS(MAP_WORD_BITS)) u_map (
    .clk, .rst, .busy(map_busy), .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
  );

  logic [WaW-1:0] pw;
  logic [BiW-1:0] pb;
  assign pw = WaW'(p >> BiW);
  assign pb = p[BiW-1:0];
  assign rd_addr = pw;
  assign wr_addr = pw;

  // current word with this cycle's page bit merged in
  always_comb begin
    wr_data     = word;
    wr_data[pb] = (req_kind == bpra_pkg::KindAlloc);
  end

  logic bit_used;
  assign bit_used = word[pb];
  logic last_in_word;
  assign last_in_word = (pb == BiW'(MAP_WORD_BITS - 1));

  // next-state logic
  always_comb begin
    state_next = state;
    case (state)
      bpra_pkg::S_IDLE:    if (in_valid && !map_busy) state_next = bpra_pkg::S_CHECK;
      bpra_pkg::S_CHECK: begin
        if (!pool_enable) state_next = bpra_pkg::S_OUT;
        else if (req_kind == bpra_pkg::KindAlloc) begin
          if (req_count == '0) state_next = bpra_pkg::S_OUT;
          else if (total == '0) state_next = bpra_pkg::S_OUT;
          else state_next = bpra_pkg::S_SCAN_RD;
        end else begin
          if (req_addr == '0 || free_end > 54'(total) || req_count == '0)
            state_next = bpra_pkg::S_OUT;
          else state_next = bpra_pkg::S_WR_RD;
        end
      end
      bpra_pkg::S_SCAN_RD: state_next = bpra_pkg::S_SCAN_LD;
      bpra_pkg::S_SCAN_LD: state_next = bpra_pkg::S_SCAN;
      bpra_pkg::S_SCAN: begin
        if (!bit_used && (run + 17'd1 >= req_count)) state_next = bpra_pkg::S_WR_RD;
        else if (p + 1'b1 >= total) state_next = bpra_pkg::S_OUT;
        else if (last_in_word) state_next = bpra_pkg::S_SCAN_RD;
      end
      bpra_pkg::S_WR_RD:   state_next = bpra_pkg::S_WR_LD;
      bpra_pkg::S_WR_LD:   state_next = bpra_pkg::S_WR;
      bpra_pkg::S_WR: begin
        if (p + 1'b1 >= wr_end) state_next = bpra_pkg::S_DONE;
        else if (last_in_word) state_next = bpra_pkg::S_WR_RD;
      end
      bpra_pkg::S_DONE:    state_next = bpra_pkg::S_OUT;
      bpra_pkg::S_OUT:     if (!out_valid || !out_stall) state_next = bpra_pkg::S_IDLE;
      default:             state_next = bpra_pkg::S_IDLE;
    endcase
  end

  // write back the word when leaving it
  always_comb begin
    wr_en = 1'b0;
    case (state)
      bpra_pkg::S_WR: wr_en = (p + 1'b1 >= wr_end) || last_in_word;
      default:        wr_en = 1'b0;
    endcase
  end

  assign in_stall = (state != bpra_pkg::S_IDLE) || map_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpra_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bpra_pkg::S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  // load the map word in the cycle after its read is issued; keep the merged word while marking
  always_ff @(posedge clk) begin
    case (state)
      bpra_pkg::S_SCAN_LD: word <= rd_data;
      bpra_pkg::S_WR_LD:   word <= rd_data;
      bpra_pkg::S_WR:      word <= wr_data;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      bpra_pkg::S_IDLE: begin
        req_kind  <= kind;
        req_count <= page_count;
        req_addr  <= address;
        total     <= (32'(pool_pages) > 32'(MAX_PAGES)) ? PW'(MAX_PAGES) : PW'(pool_pages);
        p <= '0; start <= '0; run <= '0;
        res_status <= bpra_pkg::ST_OK;
        res_addr <= '0;
      end
      bpra_pkg::S_CHECK: begin
        if (!pool_enable) res_status <= bpra_pkg::ST_UNAVAIL;
        else if (req_kind == bpra_pkg::KindAlloc) begin
          if (req_count == '0) res_status <= bpra_pkg::ST_REJECT;
          else if (total == '0) res_status <= bpra_pkg::ST_NOSPACE;
        end else begin
          if (req_addr == '0 || free_end > 54'(total)) res_status <= bpra_pkg::ST_REJECT;
          else begin
            p      <= PW'(first);
            wr_end <= PW'(free_end);
          end
        end
      end
      bpra_pkg::S_SCAN_RD: ;
      bpra_pkg::S_SCAN: begin
        if (bit_used) begin
          run   <= '0;
          start <= p + 1'b1;
        end else run <= run + 17'd1;
        if (!bit_used && (run + 17'd1 >= req_count)) begin
          p      <= start;
          wr_end <= start + PW'(req_count);
          res_addr <= pool_base + (64'(start) << bpra_pkg::PageShift);
        end else begin
          p <= p + 1'b1;
          if (p + 1'b1 >= total) res_status <= bpra_pkg::ST_NOSPACE;
        end
      end
      bpra_pkg::S_WR: begin
        p <= p + 1'b1;
      end
      default: ;
    endcase
    if (state == bpra_pkg::S_OUT && (!out_valid || !out_stall)) begin
      status        <= res_status;
      alloc_address <= res_addr;
    end
  end

  `BPRA_ASSERT_IMP(a_stall_busy, clk, rst, state != bpra_pkg::S_IDLE, in_stall, "busy but not stalling")
  `BPRA_ASSERT_IMP(a_ok_addr, clk, rst, out_valid && status != bpra_pkg::ST_OK, alloc_address == '0, "address on failure")
  `BPRA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status), "result dropped")

endmodule

### tb/tb_bitmap_page_run_allocator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_page_run_allocator_core
// Checks the first-fit page-run allocator against a behavioral page map kept
// in the bench: directed corner requests, full-pool runs, then random
// allocate/free traffic with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_bitmap_page_run_allocator_core;

  typedef struct packed {
    bpra_pkg::status_t st;
    logic [63:0]       addr;
  } alloc_result_t;

  typedef struct {
    logic [63:0] addr;
    int unsigned pages;
  } page_run_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        kind;
  logic [16:0] page_count;
  logic [63:0] address;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic [63:0] alloc_address;

  // bench copy of the block state
  bit          used_page [0:bpra_pkg::MaxPages-1];
  bit          pool_on;
  logic [63:0] pool_base;
  logic [16:0] pool_pages;

  alloc_result_t pending_results[$];
  page_run_t     live_runs[$];
  int            mismatches;
  int            requests_sent;
  int            results_seen;
  bit            no_gaps;

  bitmap_page_run_allocator_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .page_count    (page_count),
    .address       (address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .alloc_address (alloc_address)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // work out the result of one request and update the page map
  function automatic alloc_result_t serve_request(logic k, logic [16:0] cnt,
                                                  logic [63:0] addr);
    alloc_result_t res;
    int unsigned   total;
    int unsigned   start;
    int unsigned   run_len;
    bit            found;
    logic [63:0]   off;
    logic [63:0]   first;
    res.st   = bpra_pkg::ST_OK;
    res.addr = '0;
    total    = (pool_pages > bpra_pkg::MaxPages) ? bpra_pkg::MaxPages : pool_pages;
    start    = 0;
    run_len  = 0;
    found    = 1'b0;
    if (!pool_on) begin
      res.st = bpra_pkg::ST_UNAVAIL;
    end else if (k == bpra_pkg::KindAlloc) begin
      if (cnt == 0) begin
        res.st = bpra_pkg::ST_REJECT;
      end else begin
        for (int unsigned p = 0; p < total; p++) begin
          if (used_page[p]) begin
            run_len = 0;
            start   = p + 1;
          end else begin
            run_len++;
            if (run_len >= cnt) begin
              found = 1'b1;
              break;
            end
          end
        end
        if (!found) begin
          res.st = bpra_pkg::ST_NOSPACE;
        end else begin
          for (int unsigned p = start; p < start + cnt; p++) used_page[p] = 1'b1;
          res.addr = pool_base + (64'(start) << bpra_pkg::PageShift);
        end
      end
    end else begin
      if (addr == 0) begin
        res.st = bpra_pkg::ST_REJECT;
      end else begin
        off   = addr - pool_base;
        first = (off >> bpra_pkg::PageShift) + ((off[11:0] != 0) ? 64'd1 : 64'd0);
        if (first + 64'(cnt) > 64'(total)) begin
          res.st = bpra_pkg::ST_REJECT;
        end else begin
          for (int unsigned p = 32'(first); p < first + cnt; p++) used_page[p] = 1'b0;
        end
      end
    end
    return res;
  endfunction

  task automatic send_request(logic k, logic [16:0] cnt, logic [63:0] addr);
    alloc_result_t res;
    page_run_t     run;
    int            g;
    kind       <= k;
    page_count <= cnt;
    address    <= addr;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    res = serve_request(k, cnt, addr);
    pending_results.push_back(res);
    requests_sent++;
    if (k == bpra_pkg::KindAlloc && res.st == bpra_pkg::ST_OK) begin
      run.addr  = res.addr;
      run.pages = cnt;
      live_runs.push_back(run);
    end
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // drop valid and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      bpra_pkg::CfgEnable: pool_on    = data[0];
      bpra_pkg::CfgBase:   pool_base  = data;
      bpra_pkg::CfgPages:  pool_pages = data[16:0];
      default: ;
    endcase
  endtask

  task automatic set_pool(logic en, logic [63:0] base, logic [16:0] pages);
    drain();
    write_reg(bpra_pkg::CfgEnable, {63'd0, en});
    write_reg(bpra_pkg::CfgBase, base);
    write_reg(bpra_pkg::CfgPages, {47'd0, pages});
    live_runs.delete();
  endtask

  task automatic test_disabled();
    send_request(bpra_pkg::KindAlloc, 17'd1, 64'd0);
    send_request(bpra_pkg::KindFree, 17'd3, 64'h5000);
  endtask

  task automatic test_alloc_edges();
    set_pool(1'b1, 64'h0000_0000_8000_0000, 17'd64);
    send_request(bpra_pkg::KindAlloc, 17'd0, 64'd0);
    send_request(bpra_pkg::KindAlloc, 17'd1, {64{1'b1}});
    send_request(bpra_pkg::KindAlloc, 17'd64, 64'd0);
    send_request(bpra_pkg::KindAlloc, 17'd63, 64'd0);
    send_request(bpra_pkg::KindAlloc, 17'd1, 64'd0);
    send_request(bpra_pkg::KindAlloc, 17'h1FFFF, 64'd0);
  endtask

  task automatic test_free_edges();
    send_request(bpra_pkg::KindFree, 17'd1, 64'd0);
    send_request(bpra_pkg::KindFree, 17'd1, pool_base - 64'h1000);
    send_request(bpra_pkg::KindFree, 17'd5, pool_base + 60 * 4096);
    send_request(bpra_pkg::KindFree, 17'd1, pool_base + 64'h10);
    send_request(bpra_pkg::KindFree, 17'd0, pool_base);
    send_request(bpra_pkg::KindFree, 17'd2, pool_base + 2 * 4096);
    send_request(bpra_pkg::KindFree, 17'd3, pool_base + 50 * 4096);
    send_request(bpra_pkg::KindAlloc, 17'd2, 64'd0);
  endtask

  task automatic test_wrap();
    set_pool(1'b1, 64'hFFFF_FFFF_FFFF_0000, 17'd40);
    send_request(bpra_pkg::KindFree, 17'd40, pool_base);
    send_request(bpra_pkg::KindAlloc, 17'd20, 64'd0);
    send_request(bpra_pkg::KindAlloc, 17'd10, 64'd0);
    send_request(bpra_pkg::KindFree, 17'd2, 64'h3000);
  endtask

  task automatic test_full_pool();
    set_pool(1'b1, 64'h0000_0001_0000_0000, 17'd65536);
    send_request(bpra_pkg::KindFree, 17'd65536, pool_base);
    send_request(bpra_pkg::KindAlloc, 17'd65536, 64'd0);
    send_request(bpra_pkg::KindAlloc, 17'd1, 64'd0);
    set_pool(1'b1, pool_base, 17'h1FFFF);
    send_request(bpra_pkg::KindFree, 17'd1, pool_base + 64'(65535) * 4096);
    send_request(bpra_pkg::KindAlloc, 17'd1, 64'd0);
    send_request(bpra_pkg::KindFree, 17'd65536, pool_base);
  endtask

  task automatic test_random_traffic(int phase, int n_req);
    logic [16:0] pages;
    logic [63:0] base;
    page_run_t   run;
    int          r;
    int          idx;
    logic [16:0] cnt;
    logic [63:0] addr;
    pages = (phase == 4) ? 17'($urandom_range(0, 8)) : 17'($urandom_range(16, 300));
    base  = {$urandom, $urandom} & ~64'hFFF;
    set_pool(1'b1, base, pages);
    no_gaps = (phase == 1);
    // start from an empty pool
    send_request(bpra_pkg::KindFree, pages, base);
    for (int i = 0; i < n_req; i++) begin
      if (phase == 2 && i == 10) begin
        drain();
        write_reg(bpra_pkg::CfgEnable, 64'd0);
      end
      if (phase == 2 && i == 18) begin
        drain();
        write_reg(bpra_pkg::CfgEnable, 64'd1);
      end
      // let the block run dry once, halfway through the phase
      if (i == n_req / 2) drain();
      r = $urandom_range(0, 99);
      if (r >= 45 && r < 85 && live_runs.size() == 0) r = 0;
      if (r < 45) begin
        cnt = ($urandom_range(0, 9) < 8) ? 17'($urandom_range(1, 8))
                                         : 17'($urandom_range(1, pages + 2));
        send_request(bpra_pkg::KindAlloc, cnt, {$urandom, $urandom});
      end else if (r < 85) begin
        idx  = $urandom_range(0, live_runs.size() - 1);
        run  = live_runs[idx];
        live_runs.delete(idx);
        addr = run.addr;
        if ($urandom_range(0, 3) == 0) addr = addr + $urandom_range(1, 4095);
        cnt  = ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, run.pages))
                                           : 17'(run.pages);
        send_request(bpra_pkg::KindFree, cnt, addr);
      end else begin
        cnt = ($urandom_range(0, 4) == 0) ? 17'd0 : 17'($urandom_range(0, 17'h1FFFF));
        send_request(1'($urandom_range(0, 1)), cnt, {$urandom, $urandom});
      end
    end
    no_gaps = 1'b0;
  endtask

  // result stall pattern
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      n = gap_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status=%0d addr=%h", status, alloc_address);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st || alloc_address !== want.addr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected status=%0d addr=%h, got status=%0d addr=%h",
                     results_seen, want.st, want.addr, status, alloc_address);
        end
      end
    end
  end

  initial begin
    #48000000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    kind       <= 1'b0;
    page_count <= '0;
    address    <= '0;
    mismatches    = 0;
    requests_sent = 0;
    results_seen  = 0;
    no_gaps       = 1'b0;
    pool_on       = 1'b0;
    pool_base     = '0;
    pool_pages    = '0;
    foreach (used_page[p]) used_page[p] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_disabled();
    test_alloc_edges();
    test_free_edges();
    test_wrap();
    test_full_pool();
    for (int ph = 0; ph < 5; ph++) test_random_traffic(ph, 50);

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d allocate/free requests, %0d results checked", requests_sent,
             results_seen);
    $display("Covered disabled pool, rejects, full pool, address wrap, random traffic");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/bpra_pkg.sv
design/bpra_map.sv
design/bitmap_page_run_allocator_core.sv
tb/tb_bitmap_page_run_allocator_core.sv
